// File: hw/rtl/lru_key_value_cache_top_defines.svh
// ----------------------------------------------------------------------------
// LRU key-value cache assertion macros
// Shared property forms used by the cache top level.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define LKVC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("Assertion failed in the same cycle.");

// The consequent holds in the cycle after the antecedent.
`define LKVC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("Assertion failed in the following cycle.");

`endif

// File: hw/rtl/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Sizes, request and response items, and controller-datapath interfaces.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int Entries   = 16;
  localparam int KeyBits   = 16;
  localparam int ValueBits = 32;
  localparam int CapBits   = 5;
  localparam int IdxBits   = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int RankBits  = IdxBits;
  localparam int CntBits   = $clog2(Entries + 1);

  localparam logic [CapBits-1:0] CapReset = CapBits'(Entries);

  typedef enum logic {
    FUNC_GET = 1'b0,
    FUNC_PUT = 1'b1
  } func_t;

  typedef struct packed {
    func_t                func;
    logic [KeyBits-1:0]   lookup_key;
    logic [ValueBits-1:0] write_value;
  } req_t;

  typedef struct packed {
    logic                 hit;
    logic [ValueBits-1:0] read_value;
    logic                 evicted;
    logic [KeyBits-1:0]   evicted_key;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic lookup;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

// File: hw/rtl/lkvc_ctrl.sv
// ----------------------------------------------------------------------------
// LRU key-value cache controller
// Steps each item through load, lookup and update, and waits for output room.
// ----------------------------------------------------------------------------
module lkvc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  lkvc_pkg::status_t status,
  output lkvc_pkg::cmd_t    cmd
);
  import lkvc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_UPDATE
  } state_t;

  state_t state;

  assign in_stall   = (state != S_IDLE);
  assign cmd.load   = in_valid && (state == S_IDLE);
  assign cmd.lookup = (state == S_LOOKUP);
  assign cmd.update = (state == S_UPDATE) && status.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          if (status.out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/lkvc_datapath.sv
// ----------------------------------------------------------------------------
// LRU key-value cache datapath
// Entry storage, parallel key match, recency ranks and the output register.
// ----------------------------------------------------------------------------
module lkvc_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  lkvc_pkg::cmd_t                cmd,
  output lkvc_pkg::status_t             status,
  input  lkvc_pkg::req_t                in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output lkvc_pkg::rsp_t                out_item,
  input  logic                          cfg_wr_en,
  input  logic [lkvc_pkg::CapBits-1:0]  cfg_wr_data
);
  import lkvc_pkg::*;

  logic [Entries-1:0]   valid;
  logic [KeyBits-1:0]   keys   [Entries];
  logic [ValueBits-1:0] values [Entries];
  logic [RankBits-1:0]  rank   [Entries];
  logic [CntBits-1:0]   occ;
  logic [CapBits-1:0]   capacity;

  req_t               req;
  logic               hit;
  logic               evict;
  logic               insert;
  logic               slot_ok;
  logic [IdxBits-1:0] hit_idx;
  logic [IdxBits-1:0] lru_idx;
  logic [IdxBits-1:0] slot_idx;

  logic [Entries-1:0] match;
  logic [Entries-1:0] lru_mask;
  logic [Entries-1:0] free_mask;
  logic [CntBits-1:0] eff_cap;
  logic [RankBits-1:0] lru_rank;
  logic               need_evict;
  logic [IdxBits-1:0] hit_idx_next;
  logic [IdxBits-1:0] lru_idx_next;
  logic [IdxBits-1:0] slot_idx_next;
  logic [RankBits-1:0] hit_rank;
  logic [Entries-1:0] keep_valid;
  logic [Entries-1:0] insert_valid;

  assign status.out_free = !out_valid || !out_stall;

  always_comb begin
    if (capacity == '0) begin
      eff_cap = CntBits'(1);
    end else if (capacity > CapBits'(Entries)) begin
      eff_cap = CntBits'(Entries);
    end else begin
      eff_cap = CntBits'(capacity);
    end
    need_evict = (req.func == FUNC_PUT) && !(|match) && (occ >= eff_cap);
    lru_rank   = RankBits'(occ - CntBits'(1));
    for (int i = 0; i < Entries; i++) begin
      match[i]    = valid[i] && (keys[i] == req.lookup_key);
      lru_mask[i] = valid[i] && (rank[i] == lru_rank);
    end
    free_mask = ~valid | (need_evict ? lru_mask : '0);
    hit_idx_next  = '0;
    lru_idx_next  = '0;
    slot_idx_next = '0;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx_next = IdxBits'(i);
      end
      if (lru_mask[i]) begin
        lru_idx_next = IdxBits'(i);
      end
      if (free_mask[i]) begin
        slot_idx_next = IdxBits'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= in_item;
    end
    if (cmd.lookup) begin
      hit      <= |match;
      evict    <= need_evict;
      insert   <= (req.func == FUNC_PUT) && !(|match);
      slot_ok  <= |free_mask;
      hit_idx  <= hit_idx_next;
      lru_idx  <= lru_idx_next;
      slot_idx <= slot_idx_next;
    end
  end

  assign hit_rank = rank[hit_idx];

  always_comb begin
    for (int i = 0; i < Entries; i++) begin
      keep_valid[i]   = valid[i] && !(evict && (lru_idx == IdxBits'(i)));
      insert_valid[i] = keep_valid[i] || (slot_idx == IdxBits'(i));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      occ      <= '0;
      capacity <= CapReset;
      for (int i = 0; i < Entries; i++) begin
        rank[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
      if (cmd.update) begin
        if (hit) begin
          for (int i = 0; i < Entries; i++) begin
            if (valid[i] && (hit_idx != IdxBits'(i)) && (rank[i] < hit_rank)) begin
              rank[i] <= rank[i] + RankBits'(1);
            end
          end
          rank[hit_idx] <= '0;
        end else if (insert) begin
          if (slot_ok) begin
            for (int i = 0; i < Entries; i++) begin
              if (keep_valid[i]) begin
                rank[i] <= rank[i] + RankBits'(1);
              end
            end
            valid          <= insert_valid;
            rank[slot_idx] <= '0;
            if (!evict) begin
              occ <= occ + CntBits'(1);
            end
          end else if (evict) begin
            valid <= keep_valid;
            occ   <= occ - CntBits'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      if (hit && (req.func == FUNC_PUT)) begin
        values[hit_idx] <= req.write_value;
      end else if (insert && slot_ok) begin
        keys[slot_idx]   <= req.lookup_key;
        values[slot_idx] <= req.write_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.update) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_item.hit         <= hit;
      out_item.read_value  <= (hit && (req.func == FUNC_GET)) ? values[hit_idx] : '0;
      out_item.evicted     <= evict;
      out_item.evicted_key <= evict ? keys[lru_idx] : '0;
    end
  end

endmodule

// File: hw/rtl/lru_key_value_cache_top.sv
// Timing: an item is accepted in the load step, matched in the lookup step
// and its result is registered in the update step; no new item is taken
// until the last one leaves the update step; a stalled output holds it.
// Reset: synchronous, active high; clears valid marks, ranks and occupancy,
// and sets the capacity to the full entry count.
// ----------------------------------------------------------------------------
// LRU key-value cache top level
// Fully associative store with least-recently-used replacement.
// ----------------------------------------------------------------------------
`include "lru_key_value_cache_top_defines.svh"

module lru_key_value_cache_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  lkvc_pkg::req_t                in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output lkvc_pkg::rsp_t                out_item,
  input  logic                          cfg_wr_en,
  input  logic [lkvc_pkg::CapBits-1:0]  cfg_wr_data
);
  import lkvc_pkg::*;

  cmd_t    cmd;
  status_t status;

  lkvc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  lkvc_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  `LKVC_ASSERT_NEXT(a_one_item_at_a_time, in_valid && !in_stall, in_stall)
  `LKVC_ASSERT_NEXT(a_load_then_lookup, cmd.load, cmd.lookup)
  `LKVC_ASSERT_NEXT(a_update_shows_result, cmd.update, out_valid)

endmodule
